// ===== hdl/congestion_window_controller_defines.svh =====
// assertion helpers shared by the congestion window controller modules
// both expect signals named clk and rst_n in the module that uses them
`ifndef CONGESTION_WINDOW_CONTROLLER_DEFINES_SVH
`define CONGESTION_WINDOW_CONTROLLER_DEFINES_SVH

// condition holds at every edge out of reset
`define CWC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds at the clock edge after the antecedent
`define CWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/cwc_pkg.sv =====
package cwc_pkg;

    // field widths
    localparam int WIN_W = 7;
    localparam int SEQ_W = 32;
    localparam int DUP_W = 3;

    // reset and rule constants
    localparam logic [WIN_W-1:0] CWND_INIT     = 7'd1;
    localparam logic [WIN_W-1:0] SSTHRESH_RST  = 7'd16;
    localparam logic [WIN_W-1:0] MAX_WIN_RST   = 7'd32;
    localparam logic [WIN_W-1:0] RECOV_BUMP    = 7'd3;
    localparam logic [DUP_W-1:0] DUP_SAT       = 3'd4;
    localparam logic [DUP_W-1:0] DUP_TRIGGER   = 3'd3;
    localparam logic [SEQ_W-1:0] SEQ_FIRST     = 32'd1;

    typedef enum logic [1:0] {
        MODE_ACK     = 2'd0,
        MODE_TIMEOUT = 2'd1,
        MODE_SENT    = 2'd2,
        MODE_RESTART = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PH_SLOW  = 2'd0,
        PH_AVOID = 2'd1,
        PH_RECOV = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CFG_INIT_THRESH = 2'd0,
        CFG_MAX_WINDOW  = 2'd1,
        CFG_SEQ_OFFSET  = 2'd2,
        CFG_PKT_COUNT   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        mode_t            mode;
        logic [SEQ_W-1:0] ack_number;
    } in_t;

    typedef struct packed {
        logic [WIN_W-1:0] window_size;
        logic [WIN_W-1:0] threshold;
        logic [1:0]       phase;
        logic             resend_request;
        logic [SEQ_W-1:0] base_index;
        logic [SEQ_W-1:0] next_index;
        logic             send_allowed;
        logic             transfer_done;
    } out_t;

    // event decode handed to the window tracker
    typedef struct packed {
        logic step;
        logic new_ack;
        logic dup_ack;
        logic timeout;
        logic restart;
    } win_ctl_t;

    // window tracker state seen by the top level
    typedef struct packed {
        logic [WIN_W-1:0] cwnd;
        logic [WIN_W-1:0] ssthresh;
        phase_t           phase;
        logic             resend;
    } win_state_t;

    // zero reads as one
    function automatic logic [WIN_W-1:0] at_least_one(input logic [WIN_W-1:0] v);
        return (v == '0) ? CWND_INIT : v;
    endfunction

    // half of the window, never below one
    function automatic logic [WIN_W-1:0] half_floor1(input logic [WIN_W-1:0] w);
        return at_least_one(w >> 1);
    endfunction

endpackage

// ===== hdl/congestion_window_controller.sv =====
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+----------------------------------
// in       | to block  | in_valid / in_ready    | in_data (mode, ack_number)
// out      | from block| out_valid / out_ready  | out_data (window, seq state, flags)
// cfg      | to block  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one item per cycle sustained while out_ready stays high; each item is held in the input register
// and is then processed into the state registers that drive out_data
// the result fields are read straight from the state registers, which hold the
// state after the item in the output slot until that item is taken
// a stalled output holds the input register; in_ready falls only when both are full
// reset: window 1, threshold 16, slow start, base and next 1, registers 16/32/0/0
// cfg_ready is always high; writes take effect on the next cycle
`include "congestion_window_controller_defines.svh"

module congestion_window_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cwc_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cwc_pkg::out_t                 out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  cwc_pkg::cfg_idx_t             cfg_index,
    input  logic [cwc_pkg::SEQ_W-1:0]     cfg_data
);

    // configuration registers
    logic [cwc_pkg::WIN_W-1:0] init_thresh_reg;
    logic [cwc_pkg::WIN_W-1:0] max_window_reg;
    logic [cwc_pkg::SEQ_W-1:0] seq_offset_reg;
    logic [cwc_pkg::SEQ_W-1:0] pkt_count_reg;

    // input slot and output slot
    cwc_pkg::in_t inq_reg;
    logic         inq_valid_reg, inq_valid_next;
    logic         out_valid_reg, out_valid_next;
    logic         advance;
    logic         proc;

    // sequence state
    logic [cwc_pkg::SEQ_W-1:0] base_reg, base_next;
    logic [cwc_pkg::SEQ_W-1:0] next_reg, next_next;
    logic [cwc_pkg::SEQ_W-1:0] last_ack_reg, last_ack_next;
    logic                      done_reg, done_next;

    logic [cwc_pkg::SEQ_W-1:0] rel;
    logic [cwc_pkg::SEQ_W-1:0] pc_plus1;
    logic [cwc_pkg::SEQ_W-1:0] outstanding;
    logic [cwc_pkg::WIN_W-1:0] send_win;
    logic                      is_dup;
    logic                      may_send;

    cwc_pkg::win_ctl_t   win_ctl;
    cwc_pkg::win_state_t win_st;

    // handshake: output slot frees when empty or taken
    assign advance        = !out_valid_reg || out_ready;
    assign proc           = inq_valid_reg && advance;
    assign in_ready       = !inq_valid_reg || advance;
    assign inq_valid_next = (in_valid && in_ready) ? 1'b1 : (proc ? 1'b0 : inq_valid_reg);
    assign out_valid_next = proc || (out_valid_reg && !out_ready);
    assign cfg_ready      = 1'b1;

    // sequence arithmetic
    assign rel      = inq_reg.ack_number - seq_offset_reg;
    assign pc_plus1 = pkt_count_reg + 32'd1;
    assign is_dup   = inq_reg.ack_number == last_ack_reg;

    // send window check on the current state
    assign send_win    = (win_st.cwnd < cwc_pkg::at_least_one(max_window_reg))
                         ? win_st.cwnd : cwc_pkg::at_least_one(max_window_reg);
    assign outstanding = next_reg - base_reg;
    assign may_send    = !done_reg
                         && outstanding < {{(cwc_pkg::SEQ_W-cwc_pkg::WIN_W){1'b0}}, send_win}
                         && {1'b0, next_reg} <= {1'b0, pkt_count_reg} + 33'd1;

    // event decode for the window tracker
    always_comb
    begin
        win_ctl.step    = proc;
        win_ctl.new_ack = inq_reg.mode == cwc_pkg::MODE_ACK && !done_reg && !is_dup;
        win_ctl.dup_ack = inq_reg.mode == cwc_pkg::MODE_ACK && !done_reg && is_dup;
        win_ctl.timeout = inq_reg.mode == cwc_pkg::MODE_TIMEOUT;
        win_ctl.restart = inq_reg.mode == cwc_pkg::MODE_RESTART;
    end

    cwc_window u_window (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (win_ctl),
        .init_threshold (init_thresh_reg),
        .max_window     (max_window_reg),
        .st             (win_st)
    );

    // sequence state update
    always_comb
    begin
        base_next     = base_reg;
        next_next     = next_reg;
        last_ack_next = last_ack_reg;
        done_next     = done_reg;
        if (proc)
        begin
            unique case (inq_reg.mode)
                cwc_pkg::MODE_ACK:
                begin
                    if (!done_reg)
                    begin
                        if (!is_dup)
                            last_ack_next = inq_reg.ack_number;
                        if (rel >= base_reg)
                            base_next = rel + 32'd1;
                        if (rel == pc_plus1)
                            done_next = 1'b1;
                    end
                end
                cwc_pkg::MODE_TIMEOUT:
                begin
                end
                cwc_pkg::MODE_SENT:
                begin
                    if (may_send)
                        next_next = next_reg + 32'd1;
                end
                cwc_pkg::MODE_RESTART:
                begin
                    base_next     = cwc_pkg::SEQ_FIRST;
                    next_next     = cwc_pkg::SEQ_FIRST;
                    last_ack_next = '0;
                    done_next     = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inq_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= cwc_pkg::SEQ_FIRST;
            next_reg      <= cwc_pkg::SEQ_FIRST;
            last_ack_reg  <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            inq_valid_reg <= inq_valid_next;
            out_valid_reg <= out_valid_next;
            base_reg      <= base_next;
            next_reg      <= next_next;
            last_ack_reg  <= last_ack_next;
            done_reg      <= done_next;
        end
    end

    // input payload register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            inq_reg <= in_data;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_thresh_reg <= cwc_pkg::SSTHRESH_RST;
            max_window_reg  <= cwc_pkg::MAX_WIN_RST;
            seq_offset_reg  <= '0;
            pkt_count_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cwc_pkg::CFG_INIT_THRESH: init_thresh_reg <= cfg_data[cwc_pkg::WIN_W-1:0];
                cwc_pkg::CFG_MAX_WINDOW:  max_window_reg  <= cfg_data[cwc_pkg::WIN_W-1:0];
                cwc_pkg::CFG_SEQ_OFFSET:  seq_offset_reg  <= cfg_data;
                cwc_pkg::CFG_PKT_COUNT:   pkt_count_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // result fields from the post-update state
    assign out_valid               = out_valid_reg;
    assign out_data.window_size    = win_st.cwnd;
    assign out_data.threshold      = win_st.ssthresh;
    assign out_data.phase          = win_st.phase;
    assign out_data.resend_request = win_st.resend;
    assign out_data.base_index     = base_reg;
    assign out_data.next_index     = next_reg;
    assign out_data.send_allowed   = may_send;
    assign out_data.transfer_done  = done_reg;

    // checks
    `CWC_ASSERT_NEXT(a_hold_on_stall, out_valid_reg && !out_ready, $stable(base_reg) && $stable(next_reg) && $stable(win_st), "state moved while result waits")
    `CWC_ASSERT_NEXT(a_done_ignores_ack, proc && done_reg && inq_reg.mode == cwc_pkg::MODE_ACK, $stable(base_reg) && $stable(last_ack_reg) && done_reg, "ack changed state after transfer done")
    `CWC_ASSERT_NEXT(a_inq_held, inq_valid_reg && !advance, inq_valid_reg && $stable(inq_reg), "input slot lost while output stalled")

endmodule

// ===== hdl/cwc_window.sv =====
`include "congestion_window_controller_defines.svh"

module cwc_window (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cwc_pkg::win_ctl_t             ctl,
    input  logic [cwc_pkg::WIN_W-1:0]     init_threshold,
    input  logic [cwc_pkg::WIN_W-1:0]     max_window,
    output cwc_pkg::win_state_t           st
);

    logic [cwc_pkg::WIN_W-1:0] cwnd_reg, cwnd_next;
    logic [cwc_pkg::WIN_W-1:0] ssthresh_reg, ssthresh_next;
    cwc_pkg::phase_t           phase_reg, phase_next;
    logic [cwc_pkg::DUP_W-1:0] dup_reg, dup_next;
    logic                      resend_reg, resend_next;

    logic [cwc_pkg::WIN_W-1:0] eff_max;
    logic [cwc_pkg::WIN_W-1:0] half1;
    logic [cwc_pkg::DUP_W-1:0] dup_inc;
    logic [cwc_pkg::WIN_W:0]   grow_w;
    logic [cwc_pkg::WIN_W-1:0] grow_clamped;
    cwc_pkg::phase_t           grow_phase;

    // shared arithmetic for the event paths
    assign eff_max = cwc_pkg::at_least_one(max_window);
    assign half1   = cwc_pkg::half_floor1(cwnd_reg);
    assign dup_inc = (dup_reg < cwc_pkg::DUP_SAT) ? dup_reg + 3'd1 : dup_reg;

    // new ack growth: double in slow start, add one otherwise
    assign grow_w = (phase_reg == cwc_pkg::PH_SLOW) ? {cwnd_reg, 1'b0}
                                                    : {1'b0, cwnd_reg} + 8'd1;
    assign grow_clamped = (grow_w > {1'b0, eff_max}) ? eff_max
                                                     : grow_w[cwc_pkg::WIN_W-1:0];
    assign grow_phase = (phase_reg == cwc_pkg::PH_SLOW && grow_w < {1'b0, ssthresh_reg})
                        ? cwc_pkg::PH_SLOW : cwc_pkg::PH_AVOID;

    // next state per event
    always_comb
    begin
        cwnd_next     = cwnd_reg;
        ssthresh_next = ssthresh_reg;
        phase_next    = phase_reg;
        dup_next      = dup_reg;
        resend_next   = resend_reg;
        if (ctl.step)
        begin
            resend_next = 1'b0;
            if (ctl.restart)
            begin
                cwnd_next     = cwc_pkg::CWND_INIT;
                ssthresh_next = cwc_pkg::at_least_one(init_threshold);
                phase_next    = cwc_pkg::PH_SLOW;
                dup_next      = '0;
            end
            else if (ctl.timeout)
            begin
                cwnd_next     = cwc_pkg::CWND_INIT;
                ssthresh_next = half1;
                phase_next    = cwc_pkg::PH_SLOW;
            end
            else if (ctl.dup_ack)
            begin
                dup_next = dup_inc;
                if (dup_inc == cwc_pkg::DUP_TRIGGER)
                begin
                    ssthresh_next = half1;
                    cwnd_next     = half1 + cwc_pkg::RECOV_BUMP;
                    phase_next    = cwc_pkg::PH_RECOV;
                    resend_next   = 1'b1;
                end
            end
            else if (ctl.new_ack)
            begin
                dup_next   = '0;
                cwnd_next  = grow_clamped;
                phase_next = grow_phase;
            end
            else
            begin
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cwnd_reg     <= cwc_pkg::CWND_INIT;
            ssthresh_reg <= cwc_pkg::SSTHRESH_RST;
            phase_reg    <= cwc_pkg::PH_SLOW;
            dup_reg      <= '0;
            resend_reg   <= 1'b0;
        end
        else
        begin
            cwnd_reg     <= cwnd_next;
            ssthresh_reg <= ssthresh_next;
            phase_reg    <= phase_next;
            dup_reg      <= dup_next;
            resend_reg   <= resend_next;
        end
    end

    assign st.cwnd     = cwnd_reg;
    assign st.ssthresh = ssthresh_reg;
    assign st.phase    = phase_reg;
    assign st.resend   = resend_reg;

    // checks
    `CWC_ASSERT_ALWAYS(a_cwnd_nonzero, cwnd_reg != '0 && ssthresh_reg != '0, "window or threshold reached zero")
    `CWC_ASSERT_ALWAYS(a_resend_recov, !resend_reg || phase_reg == cwc_pkg::PH_RECOV, "resend outside recovery")
    `CWC_ASSERT_NEXT(a_timeout_reset, ctl.step && ctl.timeout && !ctl.restart, cwnd_reg == cwc_pkg::CWND_INIT && phase_reg == cwc_pkg::PH_SLOW && dup_reg == $past(dup_reg), "timeout did not collapse window")

endmodule

// ===== bench/tb_congestion_window_controller.sv =====
`timescale 1ns / 1ps

module tb_congestion_window_controller;

    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_ITEMS = 1150;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    cwc_pkg::in_t          in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    cwc_pkg::out_t         out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cwc_pkg::cfg_idx_t     cfg_index = cwc_pkg::CFG_INIT_THRESH;
    logic [31:0]           cfg_data = '0;

    // window and sequence state as the block should hold it
    logic [6:0]            m_cwnd;
    logic [6:0]            m_ssthresh;
    cwc_pkg::phase_t       m_phase;
    logic [2:0]            m_dups;
    logic [31:0]           m_last_ack;
    logic [31:0]           m_base;
    logic [31:0]           m_next;
    logic                  m_done;

    // register settings as the block should hold them
    logic [6:0]            c_init_thresh;
    logic [6:0]            c_max_win;
    logic [31:0]           c_offset;
    logic [31:0]           c_pkt_count;

    cwc_pkg::out_t         pending_status [$];
    cwc_pkg::out_t         want_status;
    int                    mismatches = 0;
    int                    sent_items = 0;
    int                    burst_left = 0;
    bit                    steady_sender = 1'b0;
    logic [7:0]            stall_age = '0;
    int                    stall_style = 0;

    congestion_window_controller u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // window cap, zero reads as one
    function automatic logic [6:0] window_cap();
        return (c_max_win == 7'd0) ? 7'd1 : c_max_win;
    endfunction

    // half the window, never below one
    function automatic logic [6:0] halved_window(input logic [6:0] w);
        return ((w >> 1) == 7'd0) ? 7'd1 : (w >> 1);
    endfunction

    function automatic bit can_send();
        logic [6:0]  win;
        logic [31:0] outstanding;
        win = (m_cwnd < window_cap()) ? m_cwnd : window_cap();
        outstanding = m_next - m_base;
        return !m_done && (outstanding < {25'd0, win})
            && ({1'b0, m_next} <= {1'b0, c_pkt_count} + 33'd1);
    endfunction

    function automatic void restart_transfer();
        m_cwnd     = 7'd1;
        m_ssthresh = (c_init_thresh == 7'd0) ? 7'd1 : c_init_thresh;
        m_phase    = cwc_pkg::PH_SLOW;
        m_dups     = '0;
        m_last_ack = '0;
        m_base     = 32'd1;
        m_next     = 32'd1;
        m_done     = 1'b0;
    endfunction

    // apply one event to the tracked state and return the status it yields
    function automatic cwc_pkg::out_t apply_event(input cwc_pkg::in_t ev);
        logic [31:0]   rel;
        logic [8:0]    w;
        logic          resend;
        cwc_pkg::out_t status;
        resend = 1'b0;
        case (ev.mode)
            cwc_pkg::MODE_ACK:
            begin
                if (!m_done)
                begin
                    rel = ev.ack_number - c_offset;
                    if (ev.ack_number == m_last_ack)
                    begin
                        if (m_dups < 3'd4)
                            m_dups = m_dups + 3'd1;
                        if (m_dups == 3'd3)
                        begin
                            m_ssthresh = halved_window(m_cwnd);
                            m_cwnd     = m_ssthresh + 7'd3;
                            m_phase    = cwc_pkg::PH_RECOV;
                            resend     = 1'b1;
                        end
                    end
                    else
                    begin
                        w = {2'b00, m_cwnd};
                        m_dups = '0;
                        if (m_phase == cwc_pkg::PH_SLOW)
                        begin
                            w = w << 1;
                            if (w >= {2'b00, m_ssthresh})
                                m_phase = cwc_pkg::PH_AVOID;
                        end
                        else
                        begin
                            w = w + 9'd1;
                            m_phase = cwc_pkg::PH_AVOID;
                        end
                        if (w > {2'b00, window_cap()})
                            w = {2'b00, window_cap()};
                        m_cwnd     = w[6:0];
                        m_last_ack = ev.ack_number;
                    end
                    if (rel >= m_base)
                        m_base = rel + 32'd1;
                    if (rel == c_pkt_count + 32'd1)
                        m_done = 1'b1;
                end
            end
            cwc_pkg::MODE_TIMEOUT:
            begin
                m_ssthresh = halved_window(m_cwnd);
                m_cwnd     = 7'd1;
                m_phase    = cwc_pkg::PH_SLOW;
            end
            cwc_pkg::MODE_SENT:
            begin
                if (can_send())
                    m_next = m_next + 32'd1;
            end
            default:
                restart_transfer();
        endcase
        status.window_size    = m_cwnd;
        status.threshold      = m_ssthresh;
        status.phase          = m_phase;
        status.resend_request = resend;
        status.base_index     = m_base;
        status.next_index     = m_next;
        status.send_allowed   = can_send();
        status.transfer_done  = m_done;
        return status;
    endfunction

    function automatic cwc_pkg::in_t make_event(input cwc_pkg::mode_t m,
                                                input logic [31:0] ack);
        cwc_pkg::in_t ev;
        ev.mode       = m;
        ev.ack_number = ack;
        return ev;
    endfunction

    // mostly plausible traffic around the send window, some noise
    function automatic cwc_pkg::in_t random_event();
        cwc_pkg::in_t ev;
        int           pick;
        logic [31:0]  span;
        logic [31:0]  rel;
        ev.ack_number = $urandom;
        ev.mode = cwc_pkg::MODE_ACK;
        pick = $urandom_range(0, 99);
        span = m_next - m_base;
        if (span > 32'd64)
            span = '0;
        if (pick < 40)
            ev.mode = cwc_pkg::MODE_SENT;
        else if (pick < 70)
        begin
            rel = m_base - 32'd1 + $urandom_range(0, span);
            ev.ack_number = c_offset + rel;
        end
        else if (pick < 80)
            ev.ack_number = m_last_ack;
        else if (pick < 87)
            ev.mode = cwc_pkg::MODE_TIMEOUT;
        else if (pick < 89)
            ev.mode = cwc_pkg::MODE_RESTART;
        return ev;
    endfunction

    // send one item in bursts, with random gaps unless the sender is steady, then record its status
    task automatic send_event(input cwc_pkg::in_t ev);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = steady_sender ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= ev;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_items++;
        pending_status.push_back(apply_event(ev));
    endtask

    // stop sending and wait for every outstanding status
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input logic [6:0] thr, input logic [6:0] maxw,
                                 input logic [31:0] offs, input logic [31:0] count);
        cwc_pkg::cfg_idx_t idx [4];
        logic [31:0]       vals [4];
        idx[0] = cwc_pkg::CFG_INIT_THRESH;
        idx[1] = cwc_pkg::CFG_MAX_WINDOW;
        idx[2] = cwc_pkg::CFG_SEQ_OFFSET;
        idx[3] = cwc_pkg::CFG_PKT_COUNT;
        vals[0] = {25'd0, thr};
        vals[1] = {25'd0, maxw};
        vals[2] = offs;
        vals[3] = count;
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        c_init_thresh = thr;
        c_max_win     = maxw;
        c_offset      = offs;
        c_pkt_count   = count;
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
        end
    endtask

    // receiver back-pressure, style changes each time stall_age wraps
    always @(posedge clk)
    begin
        stall_age <= stall_age + 8'd1;
        if (stall_age == 8'd0)
            stall_style <= $urandom_range(0, 3);
        case (stall_style)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= (stall_age[3:0] < 4'd11);
            default: out_ready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    // compare each status item with the oldest prediction
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (pending_status.size() == 0)
            begin
                mismatches++;
                $display("%0t: status item with none expected, actual %0h", $time, out_data);
            end
            else
            begin
                want_status = pending_status.pop_front();
                compare_field("window_size", 32'(want_status.window_size),
                              32'(out_data.window_size));
                compare_field("threshold", 32'(want_status.threshold),
                              32'(out_data.threshold));
                compare_field("phase", 32'(want_status.phase), 32'(out_data.phase));
                compare_field("resend_request", 32'(want_status.resend_request),
                              32'(out_data.resend_request));
                compare_field("base_index", want_status.base_index, out_data.base_index);
                compare_field("next_index", want_status.next_index, out_data.next_index);
                compare_field("send_allowed", 32'(want_status.send_allowed),
                              32'(out_data.send_allowed));
                compare_field("transfer_done", 32'(want_status.transfer_done),
                              32'(out_data.transfer_done));
            end
        end
    end

    // ack 0 right after reset counts as a duplicate; saturation; done freezes acks
    task automatic check_duplicate_acks();
        repeat (5) send_event(make_event(cwc_pkg::MODE_ACK, 32'h0000_0000));
        send_event(make_event(cwc_pkg::MODE_ACK, 32'h0000_0001));
        send_event(make_event(cwc_pkg::MODE_SENT, 32'h0000_0000));
        send_event(make_event(cwc_pkg::MODE_ACK, 32'hFFFF_FFFF));
        send_event(make_event(cwc_pkg::MODE_TIMEOUT, 32'h0000_0000));
        send_event(make_event(cwc_pkg::MODE_RESTART, 32'h0000_0000));
    endtask

    // zero threshold and zero window cap read as one; sequence numbers wrap
    task automatic check_wrapped_transfer();
        drain_results();
        load_settings(7'd0, 7'd0, 32'hFFFF_FFFE, 32'd3);
        send_event(make_event(cwc_pkg::MODE_RESTART, 32'h0000_0000));
        send_event(make_event(cwc_pkg::MODE_SENT, 32'h0000_0000));
        send_event(make_event(cwc_pkg::MODE_SENT, 32'h0000_0000));
        for (int rel = 1; rel <= 4; rel++)
        begin
            send_event(make_event(cwc_pkg::MODE_ACK, c_offset + 32'(rel)));
            send_event(make_event(cwc_pkg::MODE_SENT, 32'h0000_0000));
        end
        send_event(make_event(cwc_pkg::MODE_TIMEOUT, 32'h0000_0000));
    endtask

    // transfers under random settings, draining between them
    task automatic check_random_traffic();
        int          target;
        logic [6:0]  thr;
        logic [6:0]  maxw;
        logic [31:0] offs;
        logic [31:0] count;
        sent_items = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            drain_results();
            case ($urandom_range(0, 7))
                0:       thr = 7'd0;
                1:       thr = 7'd1;
                2:       thr = 7'd64;
                3:       thr = 7'd127;
                default: thr = 7'($urandom_range(1, 64));
            endcase
            case ($urandom_range(0, 7))
                0:       maxw = 7'd0;
                1:       maxw = 7'd1;
                2:       maxw = 7'd64;
                3:       maxw = 7'd127;
                default: maxw = 7'($urandom_range(1, 64));
            endcase
            case ($urandom_range(0, 3))
                0:       offs = 32'h0000_0000;
                1:       offs = 32'hFFFF_FFFF;
                default: offs = $urandom;
            endcase
            case ($urandom_range(0, 7))
                0:       count = 32'd0;
                1:       count = 32'hFFFF_FFFE;
                default: count = $urandom_range(1, 40);
            endcase
            load_settings(thr, maxw, offs, count);
            steady_sender = ($urandom_range(0, 3) == 0);
            burst_left = 0;
            send_event(make_event(cwc_pkg::MODE_RESTART, $urandom));
            target = sent_items + $urandom_range(60, 160);
            while (sent_items < target)
                send_event(random_event());
        end
    endtask

    initial
    begin
        c_init_thresh = 7'd16;
        c_max_win     = 7'd32;
        c_offset      = '0;
        c_pkt_count   = '0;
        restart_transfer();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_duplicate_acks();
        check_wrapped_transfer();
        check_random_traffic();
        drain_results();
        if (mismatches == 0)
            $display("tb_congestion_window_controller OK");
        else
            $display("tb_congestion_window_controller NOT OK");
        $finish;
    end

    // hard stop in case the handshakes hang
    initial
    begin
        #3_000_000;
        $display("tb_congestion_window_controller NOT OK");
        $finish;
    end

endmodule
